[hdl/pac_pkg.sv]
package pac_pkg;

  localparam int CoordFracBits = 23;
  localparam int AreaFracBits  = 8;

  localparam int CoordWidth = 32;
  localparam int OpWidth    = CoordWidth + 1;
  localparam int MulWidth   = 2 * OpWidth;
  localparam int SumWidth   = 64;
  localparam int ProdWidth  = 128;
  localparam int AreaWidth  = 48;
  localparam int LogWidth   = 5;

  localparam int LogMin   = -7;
  localparam int LogMax   = 15;
  localparam int LogCount = LogMax - LogMin + 1;
  localparam int LogIdxW  = $clog2(LogCount);

  localparam logic [63:0] KmNum = 64'd4007516 * 64'd4007516;
  localparam logic [63:0] KmDen = 64'd1296000000;
  localparam logic [63:0] K2Q32 = ((KmNum / KmDen) << 32)
                                  + ((((KmNum % KmDen) << 32) + KmDen / 2) / KmDen);

  localparam int ShiftBox = 2 * CoordFracBits + 32 - AreaFracBits;
  localparam int ShiftPoly = ShiftBox + 1;
  localparam logic [ProdWidth-1:0] HalfBox  = ProdWidth'(1) << (ShiftBox - 1);
  localparam logic [ProdWidth-1:0] HalfPoly = ProdWidth'(1) << (ShiftPoly - 1);

  localparam logic [AreaWidth-1:0] AreaMax = {AreaWidth{1'b1}};
  localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

  localparam logic [LogWidth-1:0] LogNone   = LogWidth'(LogMin - 1);
  localparam logic [LogWidth-1:0] LogOffset = LogWidth'(-LogMin);

  typedef logic [LogCount-1:0][AreaWidth:0] log_tab_t;

  // smallest area code v with 10 * v^2 >= 100^m * 4^F, one entry per m
  function automatic log_tab_t log_thresholds();
    log_tab_t    tab;
    logic [191:0] k_lhs;
    logic [191:0] rhs;
    logic [191:0] lo;
    logic [191:0] hi;
    logic [191:0] mid;
    int           m;
    for (int i = 0; i < LogCount; i++) begin
      m     = i + LogMin;
      k_lhs = 192'd10;
      rhs   = 192'd1 << (2 * AreaFracBits);
      for (int j = 0; j < -LogMin; j++) begin
        if (j < -m) k_lhs = k_lhs * 192'd100;
      end
      for (int j = 0; j < LogMax; j++) begin
        if (j < m) rhs = rhs * 192'd100;
      end
      lo = 192'd0;
      hi = 192'd1 << AreaWidth;
      for (int b = 0; b < AreaWidth + 2; b++) begin
        if (lo < hi) begin
          mid = (lo + hi) >> 1;
          if (mid * mid * k_lhs >= rhs) hi = mid;
          else lo = mid + 192'd1;
        end
      end
      tab[i] = lo[AreaWidth:0];
    end
    return tab;
  endfunction

  localparam log_tab_t LogThresh = log_thresholds();

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIFF,
    S_VMUL,
    S_VACC,
    S_BOX,
    S_BMUL,
    S_RAW,
    S_KMUL,
    S_KACC,
    S_ROUND,
    S_LOG,
    S_DONE
  } pac_state_e;

  typedef struct packed {
    logic load_in;
    logic vtx_diff;
    logic mul_en;
    logic mul_kprod;
    logic vtx_acc;
    logic box_ops;
    logic raw_load;
    logic kacc;
    logic round;
    logic log_step;
    logic out_load;
  } pac_cmd_t;

  typedef struct packed {
    logic last;
    logic kpp_last;
    logic log_mode;
    logic log_last;
    logic out_full;
  } pac_status_t;

endpackage

[hdl/pac_ctrl.sv]
module pac_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pac_pkg::pac_status_t status_i,
  output pac_pkg::pac_cmd_t    cmd_o
);
  import pac_pkg::*;

  pac_state_e state_q;
  pac_state_e state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd_o.vtx_diff = 1'b1;
        state_d        = S_VMUL;
      end
      S_VMUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_VACC;
      end
      S_VACC: begin
        cmd_o.vtx_acc = 1'b1;
        state_d       = status_i.last ? S_BOX : S_IDLE;
      end
      S_BOX: begin
        cmd_o.box_ops = 1'b1;
        state_d       = S_BMUL;
      end
      S_BMUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_RAW;
      end
      S_RAW: begin
        cmd_o.raw_load = 1'b1;
        state_d        = S_KMUL;
      end
      S_KMUL: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_kprod = 1'b1;
        state_d         = S_KACC;
      end
      S_KACC: begin
        cmd_o.kacc = 1'b1;
        state_d    = status_i.kpp_last ? S_ROUND : S_KMUL;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        state_d     = status_i.log_mode ? S_LOG : S_DONE;
      end
      S_LOG: begin
        cmd_o.log_step = 1'b1;
        if (status_i.log_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (!status_i.out_full) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

[hdl/pac_datapath.sv]
module pac_datapath (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_we_i,
  input  logic [1:0]                                     cfg_wdata_i,
  input  logic signed [pac_pkg::CoordWidth-1:0]          lon_deg_i,
  input  logic signed [pac_pkg::CoordWidth-1:0]          lat_deg_i,
  input  logic                                           part_first_i,
  input  logic                                           shape_last_i,
  input  logic                                           out_ready_i,
  output logic                                           out_valid_o,
  output logic [pac_pkg::AreaWidth-1:0]                  area_km2_o,
  output logic signed [pac_pkg::LogWidth-1:0]            log_area_o,
  output logic                                           zero_area_o,
  input  pac_pkg::pac_cmd_t                              cmd_i,
  output pac_pkg::pac_status_t                           status_o
);
  import pac_pkg::*;

  logic [1:0] mode_q;

  logic signed [CoordWidth-1:0] x_q, y_q;
  logic                         first_q, last_q;
  logic signed [CoordWidth-1:0] prev_lon_q, prev_lat_q;
  logic                         have_prev_q;
  logic signed [SumWidth-1:0]   area_sum_q, area_sum_d;
  logic signed [CoordWidth-1:0] xmin_q, xmax_q, ymin_q, ymax_q;
  logic                         bbox_valid_q;

  logic [OpWidth-1:0]   op_a_q, op_b_q;
  logic                 neg_q;
  logic [MulWidth-1:0]  mul_q;
  logic [SumWidth-1:0]  raw_q;
  logic [ProdWidth-1:0] prod_q;
  logic [1:0]           pi_q;
  logic [AreaWidth-1:0] area_q, area_d;
  logic [LogWidth-1:0]  lg_q;
  logic                 zero_q;
  logic [LogIdxW-1:0]   li_q;

  logic                 out_valid_q;
  logic [AreaWidth-1:0] out_area_q;
  logic [LogWidth-1:0]  out_lg_q;
  logic                 out_zero_q;

  logic signed [OpWidth-1:0]  dx, ys, bw, bh;
  logic [OpWidth-1:0]         udx, uys;
  logic [OpWidth-1:0]         mul_a, mul_b;
  logic [SumWidth-1:0]        mag;
  logic signed [SumWidth-1:0] term;
  logic signed [SumWidth:0]   sum_ext;
  logic [ProdWidth-1:0]       pp_shifted;
  logic [ProdWidth-1:0]       rnd_sum, rnd_shift;
  logic [SumWidth-1:0]        abs_sum;
  logic                       log_hit;

  assign dx  = OpWidth'(x_q) - OpWidth'(prev_lon_q);
  assign ys  = OpWidth'(y_q) + OpWidth'(prev_lat_q);
  assign udx = dx[OpWidth-1] ? OpWidth'(-dx) : OpWidth'(dx);
  assign uys = ys[OpWidth-1] ? OpWidth'(-ys) : OpWidth'(ys);
  assign bw  = OpWidth'(xmax_q) - OpWidth'(xmin_q);
  assign bh  = OpWidth'(ymax_q) - OpWidth'(ymin_q);

  always_comb begin
    if (cmd_i.mul_kprod) begin
      mul_a = {1'b0, pi_q[1] ? raw_q[63:32] : raw_q[31:0]};
      mul_b = {1'b0, pi_q[0] ? K2Q32[63:32] : K2Q32[31:0]};
    end else begin
      mul_a = op_a_q;
      mul_b = op_b_q;
    end
  end

  assign mag     = (|mul_q[MulWidth-1:SumWidth-1]) ? SumMax : mul_q[SumWidth-1:0];
  assign term    = neg_q ? -signed'(mag) : signed'(mag);
  assign sum_ext = {area_sum_q[SumWidth-1], area_sum_q} + {term[SumWidth-1], term};

  always_comb begin
    if (sum_ext[SumWidth] != sum_ext[SumWidth-1]) begin
      area_sum_d = sum_ext[SumWidth] ? SumMin : SumMax;
    end else begin
      area_sum_d = sum_ext[SumWidth-1:0];
    end
  end

  assign abs_sum = area_sum_q[SumWidth-1] ? SumWidth'(-area_sum_q) : area_sum_q;

  always_comb begin
    case (pi_q)
      2'd0:    pp_shifted = ProdWidth'(mul_q);
      2'd3:    pp_shifted = ProdWidth'(mul_q) << 64;
      default: pp_shifted = ProdWidth'(mul_q) << 32;
    endcase
  end

  assign rnd_sum   = prod_q + (mode_q[1] ? HalfPoly : HalfBox);
  assign rnd_shift = mode_q[1] ? (rnd_sum >> ShiftPoly) : (rnd_sum >> ShiftBox);
  assign area_d    = (rnd_shift > ProdWidth'(AreaMax)) ? AreaMax : rnd_shift[AreaWidth-1:0];

  assign log_hit = ({1'b0, area_q} >= LogThresh[li_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= '0;
      have_prev_q  <= 1'b0;
      bbox_valid_q <= 1'b0;
      area_sum_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      if (cmd_i.vtx_diff) bbox_valid_q <= 1'b1;
      if (cmd_i.vtx_acc) begin
        have_prev_q <= 1'b1;
        if (have_prev_q && !first_q) area_sum_q <= area_sum_d;
      end
      if (cmd_i.raw_load) begin
        have_prev_q  <= 1'b0;
        bbox_valid_q <= 1'b0;
        area_sum_q   <= '0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      x_q     <= lon_deg_i;
      y_q     <= lat_deg_i;
      first_q <= part_first_i;
      last_q  <= shape_last_i;
    end
    if (cmd_i.vtx_diff) begin
      op_a_q <= udx;
      op_b_q <= uys;
      neg_q  <= dx[OpWidth-1] != ys[OpWidth-1];
      if (!bbox_valid_q) begin
        xmin_q <= x_q;
        xmax_q <= x_q;
        ymin_q <= y_q;
        ymax_q <= y_q;
      end else begin
        if (x_q < xmin_q) xmin_q <= x_q;
        if (x_q > xmax_q) xmax_q <= x_q;
        if (y_q < ymin_q) ymin_q <= y_q;
        if (y_q > ymax_q) ymax_q <= y_q;
      end
    end
    if (cmd_i.vtx_acc) begin
      prev_lon_q <= x_q;
      prev_lat_q <= y_q;
    end
    if (cmd_i.box_ops) begin
      op_a_q <= bw;
      op_b_q <= bh;
    end
    if (cmd_i.mul_en) mul_q <= MulWidth'(mul_a) * MulWidth'(mul_b);
    if (cmd_i.raw_load) begin
      raw_q  <= mode_q[1] ? abs_sum : mul_q[SumWidth-1:0];
      prod_q <= '0;
      pi_q   <= '0;
    end
    if (cmd_i.kacc) begin
      prod_q <= prod_q + pp_shifted;
      pi_q   <= pi_q + 2'd1;
    end
    if (cmd_i.round) begin
      area_q <= area_d;
      lg_q   <= mode_q[0] ? LogNone : '0;
      zero_q <= 1'b0;
      li_q   <= '0;
    end
    if (cmd_i.log_step) begin
      li_q <= li_q + LogIdxW'(1);
      if (area_q == '0) begin
        zero_q <= 1'b1;
        lg_q   <= '0;
      end else if (log_hit) begin
        lg_q <= LogWidth'(li_q) - LogOffset;
      end
    end
    if (cmd_i.out_load) begin
      out_area_q <= area_q;
      out_lg_q   <= lg_q;
      out_zero_q <= zero_q;
    end
  end

  assign status_o.last     = last_q;
  assign status_o.kpp_last = (pi_q == 2'd3);
  assign status_o.log_mode = mode_q[0];
  assign status_o.log_last = (li_q == LogIdxW'(LogCount - 1));
  assign status_o.out_full = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign area_km2_o  = out_area_q;
  assign log_area_o  = signed'(out_lg_q);
  assign zero_area_o = out_zero_q;

endmodule

[hdl/polygon_area_accumulator.sv]
// Polygon area accumulator: takes one vertex per transaction (lon/lat in
// degrees, signed fixed point) and returns one result transaction on the
// vertex flagged shape_last: the bounding-box or trapezoid area in square km
// (unsigned Q40.8, saturating), and in the log modes the area's log10
// rounded to nearest plus a zero-area flag. Every vertex goes through the
// steps accept, difference, multiply and accumulate on one shared 33x33
// multiplier. The last vertex adds finalization (box product, four partial
// products with the km^2 scale, rounding, output load), plus a threshold
// search in the log modes. The block takes a new vertex while the
// previous result waits in the output register; a result that finds the
// output register still full waits for it before the next vertex is taken.
// area_mode is written with cfg_we_i and applies to shapes finalized after it.
module polygon_area_accumulator (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [1:0]                            cfg_wdata_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [pac_pkg::CoordWidth-1:0] lon_deg_i,
  input  logic signed [pac_pkg::CoordWidth-1:0] lat_deg_i,
  input  logic                                  part_first_i,
  input  logic                                  shape_last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [pac_pkg::AreaWidth-1:0]         area_km2_o,
  output logic signed [pac_pkg::LogWidth-1:0]   log_area_o,
  output logic                                  zero_area_o
);
  import pac_pkg::*;

  pac_cmd_t    cmd;
  pac_status_t status;

  pac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pac_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .lon_deg_i    (lon_deg_i),
    .lat_deg_i    (lat_deg_i),
    .part_first_i (part_first_i),
    .shape_last_i (shape_last_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .area_km2_o   (area_km2_o),
    .log_area_o   (log_area_o),
    .zero_area_o  (zero_area_o),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int CoordW = pac_pkg::CoordWidth;
  localparam int AreaW  = pac_pkg::AreaWidth;
  localparam int LogW   = pac_pkg::LogWidth;

  localparam logic [1:0] ModeBox     = 2'd0;
  localparam logic [1:0] ModeLogBox  = 2'd1;
  localparam logic [1:0] ModePoly    = 2'd2;
  localparam logic [1:0] ModeLogPoly = 2'd3;

  localparam int CoordFrac = 23;
  localparam int AreaFrac  = 8;
  localparam int BoxShift  = 2 * CoordFrac + 32 - AreaFrac;
  localparam int PolyShift = BoxShift + 1;

  localparam logic [63:0] KmSq   = 64'd4007516 * 64'd4007516;
  localparam logic [63:0] DegSq  = 64'd1296000000;
  localparam logic [63:0] KmPerDegSq = ((KmSq / DegSq) << 32)
                                       + ((((KmSq % DegSq) << 32) + DegSq / 2) / DegSq);

  localparam logic [AreaW-1:0] AreaSat = {AreaW{1'b1}};
  localparam logic [63:0] TermSat = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7FFF_FFFF;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;
  localparam logic signed [CoordW-1:0] OneDeg   = 32'sd8388608;

  localparam int SettleCycles   = 64;
  localparam int LongHoldCycles = 400;

  typedef struct packed {
    logic [AreaW-1:0] area_km2;
    logic [LogW-1:0]  log_area;
    logic             zero_area;
  } shape_area_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [1:0]               cfg_wdata_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [CoordW-1:0] lon_deg_i;
  logic signed [CoordW-1:0] lat_deg_i;
  logic                     part_first_i;
  logic                     shape_last_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [AreaW-1:0]         area_km2_o;
  logic signed [LogW-1:0]   log_area_o;
  logic                     zero_area_o;

  shape_area_t pending_areas[$];

  logic [1:0]               mode_shadow;
  logic signed [CoordW-1:0] prev_lon;
  logic signed [CoordW-1:0] prev_lat;
  bit                       chain_open;
  longint                   twice_area;
  logic signed [CoordW-1:0] box_xlo;
  logic signed [CoordW-1:0] box_xhi;
  logic signed [CoordW-1:0] box_ylo;
  logic signed [CoordW-1:0] box_yhi;
  bit                       box_open;

  bit idle_en;
  bit hold_request;
  int mismatches;
  int vertices_sent;
  int shapes_sent;
  int areas_checked;

  polygon_area_accumulator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .lon_deg_i   (lon_deg_i),
    .lat_deg_i   (lat_deg_i),
    .part_first_i(part_first_i),
    .shape_last_i(shape_last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .area_km2_o  (area_km2_o),
    .log_area_o  (log_area_o),
    .zero_area_o (zero_area_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [AreaW-1:0] km2_scaled(input logic [63:0] raw, input int shift);
    logic [127:0] prod;
    logic [127:0] quot;
    prod = {64'd0, raw} * {64'd0, KmPerDegSq};
    prod = prod + (128'd1 << (shift - 1));
    quot = prod >> shift;
    return (quot > {80'd0, AreaSat}) ? AreaSat : quot[AreaW-1:0];
  endfunction

  function automatic int rounded_log10(input logic [AreaW-1:0] area);
    logic [255:0] lhs0;
    logic [255:0] lhs;
    logic [255:0] rhs;
    int           n;
    bit           stop;
    lhs0 = 256'(area) * 256'(area) * 256'd10;
    n    = -8;
    stop = 1'b0;
    for (int m = -7; m <= 15; m++) begin
      if (!stop) begin
        lhs = lhs0;
        rhs = 256'd1 << (2 * AreaFrac);
        for (int i = 0; i < -m; i++) lhs = lhs * 256'd100;
        for (int i = 0; i < m; i++) rhs = rhs * 256'd100;
        if (lhs < rhs) stop = 1'b1;
        else n = m;
      end
    end
    return n;
  endfunction

  function automatic void track_vertex(input logic signed [CoordW-1:0] lon,
                                       input logic signed [CoordW-1:0] lat,
                                       input bit first, input bit last);
    longint          dx;
    longint          ys;
    longint unsigned udx;
    longint unsigned uys;
    longint unsigned mag;
    longint          term;
    logic [64:0]     acc;
    longint unsigned raw;
    longint unsigned w;
    longint unsigned h;
    shape_area_t     res;
    if (chain_open && !first) begin
      dx  = longint'(lon) - longint'(prev_lon);
      ys  = longint'(lat) + longint'(prev_lat);
      udx = (dx < 0) ? -dx : dx;
      uys = (ys < 0) ? -ys : ys;
      mag = udx * uys;
      if (mag > TermSat) mag = TermSat;
      term = ((dx < 0) != (ys < 0)) ? -longint'(mag) : longint'(mag);
      acc  = {twice_area[63], twice_area} + {term[63], term};
      if (acc[64] != acc[63]) twice_area = acc[64] ? longint'(64'h8000_0000_0000_0000)
                                                   : longint'(TermSat);
      else twice_area = acc[63:0];
    end
    prev_lon   = lon;
    prev_lat   = lat;
    chain_open = 1'b1;
    if (!box_open) begin
      box_xlo  = lon;
      box_xhi  = lon;
      box_ylo  = lat;
      box_yhi  = lat;
      box_open = 1'b1;
    end else begin
      if (lon < box_xlo) box_xlo = lon;
      if (lon > box_xhi) box_xhi = lon;
      if (lat < box_ylo) box_ylo = lat;
      if (lat > box_yhi) box_yhi = lat;
    end
    if (last) begin
      if (mode_shadow[1]) begin
        raw          = (twice_area < 0) ? -twice_area : twice_area;
        res.area_km2 = km2_scaled(raw, PolyShift);
      end else begin
        w            = longint'(box_xhi) - longint'(box_xlo);
        h            = longint'(box_yhi) - longint'(box_ylo);
        res.area_km2 = km2_scaled(w * h, BoxShift);
      end
      res.log_area  = '0;
      res.zero_area = 1'b0;
      if (mode_shadow[0]) begin
        if (res.area_km2 == 0) res.zero_area = 1'b1;
        else res.log_area = LogW'(rounded_log10(res.area_km2));
      end
      pending_areas.push_back(res);
      chain_open = 1'b0;
      twice_area = 0;
      box_open   = 1'b0;
    end
  endfunction

  always @(posedge clk_i) begin
    shape_area_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_areas.size() == 0) begin
        $display("%0t: unexpected result area_km2 %0d log_area %0d zero_area %0b",
                 $time, area_km2_o, log_area_o, zero_area_o);
        mismatches++;
      end else begin
        want = pending_areas.pop_front();
        areas_checked++;
        if (want.area_km2 !== area_km2_o) begin
          $display("%0t: area_km2 expected %0d actual %0d", $time, want.area_km2, area_km2_o);
          mismatches++;
        end
        if (want.log_area !== log_area_o) begin
          $display("%0t: log_area expected %0d actual %0d", $time,
                   $signed(want.log_area), log_area_o);
          mismatches++;
        end
        if (want.zero_area !== zero_area_o) begin
          $display("%0t: zero_area expected %0b actual %0b", $time,
                   want.zero_area, zero_area_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int stall_left;
    out_ready_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_ready_i <= 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 11) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(1, 13) - 1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_vertex(input logic signed [CoordW-1:0] lon,
                             input logic signed [CoordW-1:0] lat,
                             input bit first, input bit last);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    lon_deg_i    <= lon;
    lat_deg_i    <= lat;
    part_first_i <= first;
    shape_last_i <= last;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    track_vertex(lon, lat, first, last);
    vertices_sent++;
    if (last) shapes_sent++;
  endtask

  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_area_mode(input logic [1:0] mode);
    settle_block();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    mode_shadow = mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_shape(input int unsigned nverts, input bit noisy);
    logic signed [CoordW-1:0] cx;
    logic signed [CoordW-1:0] cy;
    logic signed [CoordW-1:0] lon;
    logic signed [CoordW-1:0] lat;
    logic signed [CoordW-1:0] jitter;
    int unsigned              spread;
    bit                       first;
    if ($urandom_range(0, 3) == 0) begin
      cx = $urandom;
      cy = $urandom;
    end else begin
      cx = $urandom_range(0, 32'd3019898880) - 32'd1509949440;
      cy = $urandom_range(0, 32'd1509949440) - 32'd754974720;
    end
    spread = $urandom_range(2, 30);
    for (int i = 0; i < nverts; i++) begin
      if (noisy) begin
        lon   = $urandom;
        lat   = $urandom;
        first = ($urandom_range(0, 1) == 1);
      end else begin
        jitter = $urandom;
        lon    = cx + (jitter >>> (31 - spread));
        jitter = $urandom;
        lat    = cy + (jitter >>> (31 - spread));
        first  = (i == 0) || ($urandom_range(0, 7) == 0);
      end
      send_vertex(lon, lat, first, i == nverts - 1);
    end
  endtask

  function automatic int unsigned pick_shape_size();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return 1;
    if (roll == 1) return $urandom_range(7, 12);
    return $urandom_range(2, 6);
  endfunction

  task automatic run_shapes(input int budget);
    int          sent;
    int unsigned n;
    sent = 0;
    while (sent < budget) begin
      n = pick_shape_size();
      send_shape(n, $urandom_range(0, 6) == 0);
      sent += n;
    end
  endtask

  task automatic test_directed_cases();
    set_area_mode(ModeBox);
    send_vertex(CoordMax, CoordMin, 1'b1, 1'b1);
    send_vertex(CoordMin, CoordMin, 1'b1, 1'b0);
    send_vertex(CoordMax, CoordMax, 1'b0, 1'b1);

    set_area_mode(ModeLogBox);
    send_vertex(32'sd0, 32'sd0, 1'b1, 1'b1);
    send_vertex(32'sd0, 32'sd0, 1'b1, 1'b0);
    send_vertex(OneDeg, OneDeg, 1'b0, 1'b1);
    send_vertex(32'sd0, 32'sd0, 1'b1, 1'b0);
    send_vertex(32'sd295, 32'sd295, 1'b0, 1'b1);

    // saturate each trapezoid term and then the sum, positive side, then a plain triangle
    set_area_mode(ModePoly);
    send_vertex(CoordMin, CoordMax, 1'b1, 1'b0);
    send_vertex(CoordMax, CoordMax, 1'b0, 1'b0);
    send_vertex(CoordMin, CoordMax, 1'b1, 1'b0);
    send_vertex(CoordMax, CoordMax, 1'b0, 1'b1);
    send_vertex(32'sd0, 32'sd0, 1'b0, 1'b0);
    send_vertex(OneDeg * 10, 32'sd0, 1'b0, 1'b0);
    send_vertex(32'sd0, OneDeg * 10, 1'b0, 1'b1);

    set_area_mode(ModeLogPoly);
    send_vertex(CoordMax, CoordMax, 1'b1, 1'b0);
    send_vertex(CoordMin, CoordMax, 1'b0, 1'b0);
    send_vertex(CoordMax, CoordMax, 1'b1, 1'b0);
    send_vertex(CoordMin, CoordMax, 1'b0, 1'b1);

    // switch mode while a shape is open
    send_vertex(32'sd0, 32'sd0, 1'b1, 1'b0);
    send_vertex(OneDeg, 32'sd0, 1'b0, 1'b0);
    send_vertex(OneDeg, OneDeg, 1'b0, 1'b0);
    set_area_mode(ModeBox);
    send_vertex(32'sd0, OneDeg, 1'b0, 1'b1);
  endtask

  task automatic test_random_modes();
    idle_en = 1'b1;
    set_area_mode(ModeLogPoly);
    run_shapes(250);
    set_area_mode(ModeBox);
    run_shapes(250);
    set_area_mode(ModePoly);
    run_shapes(250);
    set_area_mode(ModeLogBox);
    run_shapes(250);
  endtask

  task automatic test_backpressure();
    idle_en = 1'b0;
    set_area_mode(ModeLogPoly);
    hold_request = 1'b1;
    for (int i = 0; i < 30; i++) send_shape(2, 1'b0);
    idle_en = 1'b1;
  endtask

  task automatic test_steady_stream();
    idle_en = 1'b0;
    set_area_mode(ModePoly);
    run_shapes(120);
    set_area_mode(ModeLogBox);
    run_shapes(120);
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 2'd0;
    in_valid_i   = 1'b0;
    lon_deg_i    = '0;
    lat_deg_i    = '0;
    part_first_i = 1'b0;
    shape_last_i = 1'b0;
    mode_shadow  = ModeBox;
    chain_open   = 1'b0;
    twice_area   = 0;
    box_open     = 1'b0;
    box_xlo      = '0;
    box_xhi      = '0;
    box_ylo      = '0;
    box_yhi      = '0;
    prev_lon     = '0;
    prev_lat     = '0;
    idle_en      = 1'b1;
    hold_request = 1'b0;
    mismatches   = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_modes();
    test_backpressure();
    test_steady_stream();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_areas.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d vertices in %0d shapes, checked %0d areas in all four modes",
             vertices_sent, shapes_sent, areas_checked);
    $display("Included saturation, split rings, a long output hold and random stalls");
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
